// File: rtl/lrr_pkg.sv
// lrr_pkg: shared constants, codes and types of the line/rectangle rasterizer
// no dependencies; compiled before every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package lrr_pkg;

    localparam int COORD_BITS  = 13;
    localparam int MAX_AREA    = 4096;

    localparam int C_DIFF_W    = COORD_BITS + 1;
    localparam int C_SUM_W     = C_DIFF_W + 1;
    localparam int C_DIM_W     = 13;
    localparam int C_PITCH_W   = 14;
    localparam int C_DATA_W    = 32;
    localparam int C_BYTES_W   = 3;
    localparam int C_INDEX_W   = 25;
    localparam int C_XY_W      = $clog2(MAX_AREA);
    localparam int C_PROD_W    = C_XY_W + C_PITCH_W + 1;
    localparam int C_OP_W      = 2;
    localparam int C_REG_IDX_W = 3;

    // operation codes
    localparam logic [C_OP_W-1:0] OP_LINE = 2'd0;
    localparam logic [C_OP_W-1:0] OP_RECT = 2'd1;
    localparam logic [C_OP_W-1:0] OP_FILL = 2'd2;
    localparam logic [C_OP_W-1:0] OP_STEP = 2'd3;

    // register indexes
    localparam logic [C_REG_IDX_W-1:0] REG_AREA_WIDTH  = 3'd0;
    localparam logic [C_REG_IDX_W-1:0] REG_AREA_HEIGHT = 3'd1;
    localparam logic [C_REG_IDX_W-1:0] REG_ROW_PITCH   = 3'd2;
    localparam logic [C_REG_IDX_W-1:0] REG_PIXEL_VALUE = 3'd3;
    localparam logic [C_REG_IDX_W-1:0] REG_PIXEL_BYTES = 3'd4;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [C_DIFF_W-1:0]   t_diff;

    typedef struct packed {
        logic [C_OP_W-1:0] operation;
        t_coord            x_start;
        t_coord            y_start;
        t_coord            x_end;
        t_coord            y_end;
    } t_cmd;

    typedef struct packed {
        logic [C_DIM_W-1:0]   clip_w;
        logic [C_DIM_W-1:0]   clip_h;
        logic [C_PITCH_W-1:0] pitch;
        logic [C_DATA_W-1:0]  data;
        logic                 size_ok;
    } t_cfg;

    typedef struct packed {
        logic  active;
        t_diff x;
        t_diff y;
        logic  done;
    } t_pix;

endpackage

`default_nettype wire

// File: rtl/lrr_intf.sv
// lrr_intf: valid/ready channel interfaces of the rasterizer (command, pixel, config)
// depends on lrr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface lrr_cmd_if;
    import lrr_pkg::*;
    logic              valid;
    logic              ready;
    logic [C_OP_W-1:0] operation;
    t_coord            x_start;
    t_coord            y_start;
    t_coord            x_end;
    t_coord            y_end;
    modport source (output valid, operation, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, operation, x_start, y_start, x_end, y_end, output ready);
endinterface

interface lrr_pix_if;
    import lrr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [C_INDEX_W-1:0] pixel_index;
    logic [C_DATA_W-1:0]  pixel_data;
    logic                 write_enable;
    logic                 done_res;
    modport source (output valid, pixel_index, pixel_data, write_enable, done_res,
                    input ready);
    modport sink   (input valid, pixel_index, pixel_data, write_enable, done_res,
                    output ready);
endinterface

interface lrr_cfg_if;
    import lrr_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [C_REG_IDX_W-1:0] index;
    logic [C_DATA_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/lrr_cfg_regs.sv
// lrr_cfg_regs: configuration registers and the derived clip, mask and size check
// depends on lrr_pkg and lrr_intf
`timescale 1ns / 1ps
`default_nettype none

module lrr_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lrr_cfg_if.sink       i_cfg,
    output lrr_pkg::t_cfg o_cfg
);
    import lrr_pkg::*;

    localparam logic [C_BYTES_W-1:0] BPP_1 = 3'd1;
    localparam logic [C_BYTES_W-1:0] BPP_2 = 3'd2;
    localparam logic [C_BYTES_W-1:0] BPP_4 = 3'd4;

    logic [C_DIM_W-1:0]   r_area_w;
    logic [C_DIM_W-1:0]   r_area_h;
    logic [C_PITCH_W-1:0] r_pitch;
    logic [C_DATA_W-1:0]  r_value;
    logic [C_BYTES_W-1:0] r_bytes;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_w <= '0;
            r_area_h <= '0;
            r_pitch  <= '0;
            r_value  <= '0;
            r_bytes  <= BPP_4;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_AREA_WIDTH:  r_area_w <= i_cfg.data[C_DIM_W-1:0];
                REG_AREA_HEIGHT: r_area_h <= i_cfg.data[C_DIM_W-1:0];
                REG_ROW_PITCH:   r_pitch  <= i_cfg.data[C_PITCH_W-1:0];
                REG_PIXEL_VALUE: r_value  <= i_cfg.data;
                REG_PIXEL_BYTES: r_bytes  <= i_cfg.data[C_BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.clip_w  = (int'(r_area_w) > MAX_AREA) ? C_DIM_W'(MAX_AREA) : r_area_w;
        o_cfg.clip_h  = (int'(r_area_h) > MAX_AREA) ? C_DIM_W'(MAX_AREA) : r_area_h;
        o_cfg.pitch   = r_pitch;
        o_cfg.size_ok = (r_bytes == BPP_1) || (r_bytes == BPP_2) || (r_bytes == BPP_4);
        case (r_bytes)
            BPP_1:   o_cfg.data = C_DATA_W'(r_value[7:0]);
            BPP_2:   o_cfg.data = C_DATA_W'(r_value[15:0]);
            default: o_cfg.data = r_value;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/lrr_walker.sv
// lrr_walker: command state and the per-pixel walk of lines, outlines and fills
// depends on lrr_pkg
`timescale 1ns / 1ps
`default_nettype none

module lrr_walker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  lrr_pkg::t_cmd i_cmd,
    output lrr_pkg::t_pix o_pix
);
    import lrr_pkg::*;

    typedef struct packed {
        logic   ok;
        logic   ycase;
        logic   desc;
        t_coord start;
        t_coord limit;
        t_diff  quot;
        t_diff  den;
        t_diff  step;
    } t_line;

    typedef struct packed {
        logic   ycase;
        logic   desc;
        t_coord major;
        t_coord limit;
        t_diff  quot;
        t_diff  rem;
        t_diff  den;
        t_diff  step;
    } t_walk;

    // the exact start minor coordinate is always an end point, so the
    // remainder starts at zero and no division is needed
    function automatic t_line line_setup(t_coord ax_i, t_coord ay_i,
                                         t_coord bx_i, t_coord by_i);
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
        t_coord t;
        t_diff  dx;
        t_diff  dy;
        t_line  l;
        ax = ax_i;
        ay = ay_i;
        bx = bx_i;
        by = by_i;
        if (bx < ax) begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
        end
        dx = t_diff'(bx) - t_diff'(ax);
        dy = t_diff'(by) - t_diff'(ay);
        l.ycase = 1'b0;
        l.desc  = 1'b0;
        l.step  = '0;
        l.den   = t_diff'(1);
        if (dx == 0) begin
            if (by < ay) begin
                t = ay; ay = by; by = t;
            end
            l.ycase = 1'b1;
            l.start = ay;
            l.limit = by;
            l.quot  = t_diff'(ax);
        end else if (dy == 0) begin
            l.start = ax;
            l.limit = bx;
            l.quot  = t_diff'(ay);
        end else if (dy > dx) begin
            l.ycase = 1'b1;
            l.start = ay;
            l.limit = by;
            l.quot  = t_diff'(ax);
            l.step  = dx;
            l.den   = dy;
        end else if (-dy > dx) begin
            l.ycase = 1'b1;
            l.start = by;
            l.limit = ay;
            l.quot  = t_diff'(bx);
            l.step  = -dx;
            l.den   = -dy;
        end else if (dy < 0) begin
            l.desc  = 1'b1;
            l.start = bx;
            l.limit = ax;
            l.quot  = t_diff'(by);
            l.step  = -dy;
            l.den   = dx;
        end else begin
            l.start = ax;
            l.limit = bx;
            l.quot  = t_diff'(ay);
            l.step  = dy;
            l.den   = dx;
        end
        l.ok = (l.start != l.limit);
        return l;
    endfunction

    function automatic t_walk walk_from(t_line l);
        t_walk w;
        w.ycase = l.ycase;
        w.desc  = l.desc;
        w.major = l.start;
        w.limit = l.limit;
        w.quot  = l.quot;
        w.rem   = '0;
        w.den   = l.den;
        w.step  = l.step;
        return w;
    endfunction

    logic [C_OP_W-1:0] r_kind;
    logic [C_OP_W-1:0] n_kind;
    logic              r_busy;
    logic              n_busy;
    logic [1:0]        r_edge;
    logic [1:0]        n_edge;
    t_walk             r_ln;
    t_walk             n_ln;
    t_coord            r_corner [4];
    t_coord            n_corner [4];
    t_coord            r_fill;
    t_coord            n_fill;

    t_line                 line_l;
    t_coord                rc [4];
    logic [2:0]            e0;
    t_line                 edge_l [4];
    logic                  rect_found;
    logic [1:0]            rect_e;
    t_walk                 rect_ln;
    t_diff                 minor;
    t_coord                major_n;
    logic signed [C_SUM_W-1:0] rem_sum;
    logic                  is_cmd;
    logic                  is_step;

    always_comb begin
        is_cmd  = i_fire && (i_cmd.operation != OP_STEP);
        is_step = i_fire && (i_cmd.operation == OP_STEP);
        line_l  = line_setup(i_cmd.x_start, i_cmd.y_start, i_cmd.x_end, i_cmd.y_end);

        // outline edges come from the new corners on a command, else the stored ones
        if (i_cmd.operation != OP_STEP) begin
            rc[0] = i_cmd.x_start;
            rc[1] = i_cmd.y_start;
            rc[2] = i_cmd.x_end;
            rc[3] = i_cmd.y_end;
            e0    = '0;
        end else begin
            rc = r_corner;
            e0 = {1'b0, r_edge} + 3'd1;
        end
        edge_l[0] = line_setup(rc[0], rc[1], rc[2], rc[1]);
        edge_l[1] = line_setup(rc[0], rc[1], rc[0], rc[3]);
        edge_l[2] = line_setup(rc[2], rc[1], rc[2], rc[3]);
        edge_l[3] = line_setup(rc[0], rc[3], rc[2], rc[3]);
        rect_found = 1'b0;
        rect_e     = '0;
        rect_ln    = walk_from(edge_l[0]);
        for (int e = 0; e < 4; e++) begin
            if (!rect_found && (3'(e) >= e0) && edge_l[e].ok) begin
                rect_found = 1'b1;
                rect_e     = 2'(e);
                rect_ln    = walk_from(edge_l[e]);
            end
        end

        // truncate toward zero from the floored quotient
        minor   = r_ln.quot + (((r_ln.quot < 0) && (r_ln.rem != 0)) ? t_diff'(1) : t_diff'(0));
        major_n = r_ln.desc ? (r_ln.major - t_coord'(1)) : (r_ln.major + t_coord'(1));
        rem_sum = C_SUM_W'(r_ln.rem) + C_SUM_W'(r_ln.step);

        n_kind   = r_kind;
        n_busy   = r_busy;
        n_edge   = r_edge;
        n_ln     = r_ln;
        n_corner = r_corner;
        n_fill   = r_fill;

        o_pix.active = r_busy;
        o_pix.x      = '0;
        o_pix.y      = '0;

        if (is_cmd) begin
            n_kind      = i_cmd.operation;
            n_corner[0] = i_cmd.x_start;
            n_corner[1] = i_cmd.y_start;
            n_corner[2] = i_cmd.x_end;
            n_corner[3] = i_cmd.y_end;
            unique case (i_cmd.operation)
                OP_LINE: begin
                    n_ln   = walk_from(line_l);
                    n_busy = line_l.ok;
                end
                OP_RECT: begin
                    if (rect_found) begin
                        n_ln = rect_ln;
                    end
                    n_edge = rect_found ? rect_e : 2'd0;
                    n_busy = rect_found;
                end
                OP_FILL: begin
                    if (i_cmd.x_end < i_cmd.x_start) begin
                        n_corner[0] = i_cmd.x_end;
                        n_corner[2] = i_cmd.x_start;
                    end
                    if (i_cmd.y_end < i_cmd.y_start) begin
                        n_corner[1] = i_cmd.y_end;
                        n_corner[3] = i_cmd.y_start;
                    end
                    n_fill      = n_corner[0];
                    n_ln.major  = n_corner[1];
                    n_ln.limit  = n_corner[3];
                    n_busy      = 1'b1;
                end
                default: ;
            endcase
        end else if (r_busy) begin
            if (r_kind == OP_FILL) begin
                o_pix.x = t_diff'(r_fill);
                o_pix.y = t_diff'(r_ln.major);
            end else if (r_ln.ycase) begin
                o_pix.x = minor;
                o_pix.y = t_diff'(r_ln.major);
            end else begin
                o_pix.x = t_diff'(r_ln.major);
                o_pix.y = minor;
            end
            if (is_step) begin
                if (r_kind == OP_FILL) begin
                    if (r_fill >= r_corner[2]) begin
                        n_fill = r_corner[0];
                        if (r_ln.major >= r_ln.limit) begin
                            n_busy = 1'b0;
                        end else begin
                            n_ln.major = r_ln.major + t_coord'(1);
                        end
                    end else begin
                        n_fill = r_fill + t_coord'(1);
                    end
                end else begin
                    n_ln.major = major_n;
                    if (rem_sum >= C_SUM_W'(r_ln.den)) begin
                        n_ln.rem  = t_diff'(rem_sum - C_SUM_W'(r_ln.den));
                        n_ln.quot = r_ln.quot + t_diff'(1);
                    end else if (rem_sum < 0) begin
                        n_ln.rem  = t_diff'(rem_sum + C_SUM_W'(r_ln.den));
                        n_ln.quot = r_ln.quot - t_diff'(1);
                    end else begin
                        n_ln.rem  = t_diff'(rem_sum);
                    end
                    if (major_n == r_ln.limit) begin
                        if (r_kind == OP_RECT) begin
                            if (rect_found) begin
                                n_ln = rect_ln;
                            end
                            n_edge = rect_found ? rect_e : 2'd0;
                            n_busy = rect_found;
                        end else begin
                            n_busy = 1'b0;
                        end
                    end
                end
            end
        end
        o_pix.done = !n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= OP_LINE;
            r_busy   <= 1'b0;
            r_edge   <= '0;
            r_ln     <= '0;
            r_corner <= '{default: '0};
            r_fill   <= '0;
        end else begin
            r_kind   <= n_kind;
            r_busy   <= n_busy;
            r_edge   <= n_edge;
            r_ln     <= n_ln;
            r_corner <= n_corner;
            r_fill   <= n_fill;
        end
    end

endmodule

`default_nettype wire

// File: rtl/line_rect_rasterizer_unit.sv
// line_rect_rasterizer_unit: top level; input register, walker, clip stage, index stage
// depends on lrr_pkg, lrr_intf, lrr_cfg_regs and lrr_walker
//
//  channel  dir  port   handshake    word
//  command  in   i_cmd  valid/ready  operation, x_start, y_start, x_end, y_end
//  pixel    out  o_pix  valid/ready  pixel_index, pixel_data, write_enable, done_res
//  config   in   i_cfg  valid/ready  register index, write data (always ready)
//
// one command word per cycle sustained while o_pix is ready; a step word's pixel passes
// the input register, clip register and index register before it is offered
// the walker's line/fill state update is combinational, which sets the 1-per-cycle rate
// command words update the state and give no pixel word
// i_rst_n is synchronous, active low, and clears the walker, the stage valids and config
// each stage holds while the next is full; empty stages keep accepting behind a stall
`timescale 1ns / 1ps
`default_nettype none

module line_rect_rasterizer_unit (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lrr_cmd_if.sink  i_cmd,
    lrr_pix_if.source o_pix,
    lrr_cfg_if.sink  i_cfg
);
    import lrr_pkg::*;

    t_cfg cfg;
    t_pix pix;

    // input register
    logic r_a_v;
    t_cmd r_a;
    logic rdy_a;
    logic adv_a;

    // clip register
    logic                r_b_v;
    logic [C_XY_W-1:0]   r_b_x;
    logic [C_XY_W-1:0]   r_b_y;
    logic                r_b_we;
    logic [C_DATA_W-1:0] r_b_data;
    logic                r_b_done;
    logic                rdy_b;

    // output register
    logic                 r_o_v;
    logic [C_INDEX_W-1:0] r_o_index;
    logic [C_DATA_W-1:0]  r_o_data;
    logic                 r_o_we;
    logic                 r_o_done;
    logic                 rdy_o;

    logic                we;
    logic [C_PROD_W-1:0] addr_sum;

    lrr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    lrr_walker u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (adv_a),
        .i_cmd   (r_a),
        .o_pix   (pix)
    );

    assign rdy_o       = !r_o_v || o_pix.ready;
    assign rdy_b       = !r_b_v || rdy_o;
    assign rdy_a       = !r_a_v || rdy_b;
    assign adv_a       = r_a_v && rdy_b;
    assign i_cmd.ready = rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (rdy_a) begin
            r_a_v <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_cmd.valid) begin
            r_a.operation <= i_cmd.operation;
            r_a.x_start   <= i_cmd.x_start;
            r_a.y_start   <= i_cmd.y_start;
            r_a.x_end     <= i_cmd.x_end;
            r_a.y_end     <= i_cmd.y_end;
        end
    end

    assign we = pix.active && cfg.size_ok
             && (pix.x >= 0) && (int'(pix.x) < int'(cfg.clip_w))
             && (pix.y >= 0) && (int'(pix.y) < int'(cfg.clip_h));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (rdy_b) begin
            r_b_v <= adv_a && (r_a.operation == OP_STEP);
        end
    end

    // dropped pixels carry zero index and data
    always_ff @(posedge i_clk) begin
        if (rdy_b) begin
            r_b_x    <= we ? C_XY_W'(pix.x) : '0;
            r_b_y    <= we ? C_XY_W'(pix.y) : '0;
            r_b_we   <= we;
            r_b_data <= we ? cfg.data : '0;
            r_b_done <= pix.done;
        end
    end

    assign addr_sum = C_PROD_W'(r_b_y) * C_PROD_W'(cfg.pitch) + C_PROD_W'(r_b_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (rdy_o) begin
            r_o_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_o) begin
            r_o_index <= C_INDEX_W'(addr_sum);
            r_o_data  <= r_b_data;
            r_o_we    <= r_b_we;
            r_o_done  <= r_b_done;
        end
    end

    assign o_pix.valid        = r_o_v;
    assign o_pix.pixel_index  = r_o_index;
    assign o_pix.pixel_data   = r_o_data;
    assign o_pix.write_enable = r_o_we;
    assign o_pix.done_res     = r_o_done;

    // a command word never produces a pixel word
    a_cmd_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv_a && (r_a.operation != OP_STEP)) |=> !r_b_v)
        else $error("command word produced a pixel word");

    // a step while idle answers done with no write
    a_idle_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv_a && (r_a.operation == OP_STEP) && !pix.active)
        |=> (r_b_v && r_b_done && !r_b_we))
        else $error("idle step did not give the idle answer");

    // a dropped pixel leaves index and data at zero
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && !r_o_we) |-> ((r_o_index == '0) && (r_o_data == '0)))
        else $error("dropped pixel carries nonzero index or data");

endmodule

`default_nettype wire

// File: tb/line_rect_rasterizer_unit_test.sv
// line_rect_rasterizer_unit_test: self-checking bench for the line/rectangle rasterizer
// needs lrr_pkg, lrr_intf and the rtl of line_rect_rasterizer_unit; keeps its own
// model of the walker and the clip/index stages and checks every pixel word in order
`timescale 1ns / 1ps

module line_rect_rasterizer_unit_test;

    import lrr_pkg::*;

    typedef struct packed {
        logic [C_INDEX_W-1:0] index;
        logic [C_DATA_W-1:0]  data;
        logic                 write_enable;
        logic                 done;
    } pixel_word_t;

    logic i_clk;
    logic i_rst_n;

    lrr_cmd_if cmd_ch ();
    lrr_pix_if pix_ch ();
    lrr_cfg_if cfg_ch ();

    line_rect_rasterizer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_pix   (pix_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // expected pixel words, oldest first
    pixel_word_t pending_pixels[$];

    int  error_count    = 0;
    int  pixels_checked = 0;
    int  words_sent     = 0;
    bit  no_idle        = 1'b0;
    bit  pix_hold_req   = 1'b0;

    // register copies
    logic [C_DIM_W-1:0]   cfg_width  = '0;
    logic [C_DIM_W-1:0]   cfg_height = '0;
    logic [C_PITCH_W-1:0] cfg_pitch  = '0;
    logic [C_DATA_W-1:0]  cfg_value  = '0;
    logic [C_BYTES_W-1:0] cfg_bytes  = 3'd4;

    // walker copy
    logic [C_OP_W-1:0] walk_kind = OP_LINE;
    bit walk_busy = 1'b0;
    bit maj_is_y  = 1'b0;
    bit maj_down  = 1'b0;
    int edge_idx  = 0;
    int corner[4] = '{0, 0, 0, 0};
    int maj_pos   = 0;
    int maj_lim   = 0;
    int min_q     = 0;
    int min_r     = 0;
    int min_den   = 1;
    int min_step  = 0;
    int fill_x    = 0;

    // ---------------------------------------------------------------- model

    // sets up one half-open line; minor axis kept as floored quotient and remainder
    function automatic bit setup_line(int ax, int ay, int bx, int by);
        int t, dx, dy, base, origin, start, limit, num, den;
        bit ycase, desc;
        longint acc, q, r;
        ycase = 1'b0;
        desc  = 1'b0;
        if (bx < ax) begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
        end
        dx = bx - ax;
        dy = by - ay;
        if (dx == 0) begin
            if (by < ay) begin
                t = ay; ay = by; by = t;
            end
            ycase = 1'b1; start = ay; limit = by; base = ax; origin = ay; num = 0; den = 1;
        end else if (dy == 0) begin
            start = ax; limit = bx; base = ay; origin = ax; num = 0; den = 1;
        end else if (dy > dx) begin
            ycase = 1'b1; start = ay; limit = by; base = ax; origin = ay; num = dx; den = dy;
        end else if (-dy > dx) begin
            ycase = 1'b1; start = by; limit = ay; base = ax; origin = ay; num = -dx; den = -dy;
        end else if (dy < 0) begin
            desc = 1'b1; start = bx; limit = ax; base = ay; origin = ax; num = dy; den = dx;
        end else begin
            start = ax; limit = bx; base = ay; origin = ax; num = dy; den = dx;
        end
        acc = longint'(base) * den + longint'(start - origin) * num;
        q = acc / den;
        r = acc % den;
        if (r < 0) begin
            r += den;
            q--;
        end
        maj_is_y = ycase;
        maj_down = desc;
        maj_pos  = start;
        maj_lim  = limit;
        min_q    = int'(q);
        min_r    = int'(r);
        min_den  = den;
        min_step = desc ? -num : num;
        return start != limit;
    endfunction

    // finds the next outline edge with pixels, starting at first_edge
    function automatic void start_outline_edge(int first_edge);
        int  e;
        bit  found;
        found = 1'b0;
        for (e = first_edge; e < 4 && !found; e++) begin
            case (e)
                0: found = setup_line(corner[0], corner[1], corner[2], corner[1]);
                1: found = setup_line(corner[0], corner[1], corner[0], corner[3]);
                2: found = setup_line(corner[2], corner[1], corner[2], corner[3]);
                default: found = setup_line(corner[0], corner[3], corner[2], corner[3]);
            endcase
            if (found) edge_idx = e;
        end
        if (!found) edge_idx = 0;
        walk_busy = found;
    endfunction

    function automatic void advance_line();
        maj_pos += maj_down ? -1 : 1;
        min_r += min_step;
        if (min_r >= min_den) begin
            min_r -= min_den;
            min_q++;
        end else if (min_r < 0) begin
            min_r += min_den;
            min_q--;
        end
        if (maj_pos == maj_lim) begin
            if (walk_kind == OP_RECT) start_outline_edge(edge_idx + 1);
            else walk_busy = 1'b0;
        end
    endfunction

    // updates the walker copy for one accepted word and queues the pixel a step gives
    function automatic void rasterize_word(logic [C_OP_W-1:0] op, t_coord xs, t_coord ys,
                                           t_coord xe, t_coord ye);
        int x, y, t, minor, w, h;
        bit we;
        logic [63:0] idx_full;
        pixel_word_t pw;
        pw = '0;
        if (op != OP_STEP) begin
            corner[0] = xs;
            corner[1] = ys;
            corner[2] = xe;
            corner[3] = ye;
            walk_kind = op;
            if (op == OP_LINE) begin
                walk_busy = setup_line(corner[0], corner[1], corner[2], corner[3]);
            end else if (op == OP_RECT) begin
                start_outline_edge(0);
            end else begin
                if (corner[2] < corner[0]) begin
                    t = corner[0]; corner[0] = corner[2]; corner[2] = t;
                end
                if (corner[3] < corner[1]) begin
                    t = corner[1]; corner[1] = corner[3]; corner[3] = t;
                end
                fill_x    = corner[0];
                maj_pos   = corner[1];
                maj_lim   = corner[3];
                walk_busy = 1'b1;
            end
            return;
        end
        if (!walk_busy) begin
            pw.done = 1'b1;
            pending_pixels.push_back(pw);
            return;
        end
        if (walk_kind == OP_FILL) begin
            x = fill_x;
            y = maj_pos;
            if (fill_x >= corner[2]) begin
                fill_x = corner[0];
                if (maj_pos >= maj_lim) walk_busy = 1'b0;
                else maj_pos++;
            end else begin
                fill_x++;
            end
        end else begin
            // truncate toward zero from the floored form
            minor = min_q + ((min_q < 0 && min_r != 0) ? 1 : 0);
            if (maj_is_y) begin
                x = minor;
                y = maj_pos;
            end else begin
                x = maj_pos;
                y = minor;
            end
            advance_line();
        end
        w  = (cfg_width > MAX_AREA) ? MAX_AREA : int'(cfg_width);
        h  = (cfg_height > MAX_AREA) ? MAX_AREA : int'(cfg_height);
        we = x >= 0 && y >= 0 && x < w && y < h &&
             (cfg_bytes == 3'd1 || cfg_bytes == 3'd2 || cfg_bytes == 3'd4);
        if (we) begin
            idx_full = 64'(y) * 64'(cfg_pitch) + 64'(x);
            pw.index = idx_full[C_INDEX_W-1:0];
            case (cfg_bytes)
                3'd1: pw.data = {24'h0, cfg_value[7:0]};
                3'd2: pw.data = {16'h0, cfg_value[15:0]};
                default: pw.data = cfg_value;
            endcase
        end
        pw.write_enable = we;
        pw.done = !walk_busy;
        pending_pixels.push_back(pw);
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_pixel
        pixel_word_t want;
        if (i_rst_n === 1'b1 && pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) begin
            if (pending_pixels.size() == 0) begin
                error_count++;
                $display("%0t ns: pixel word with none expected, expected nothing actual %0h",
                         $time, pix_ch.pixel_index);
            end else begin
                want = pending_pixels.pop_front();
                compare_field("pixel_index", 32'(want.index), 32'(pix_ch.pixel_index));
                compare_field("pixel_data", want.data, pix_ch.pixel_data);
                compare_field("write_enable", 32'(want.write_enable),
                              32'(pix_ch.write_enable));
                compare_field("done_res", 32'(want.done), 32'(pix_ch.done_res));
                pixels_checked++;
            end
        end
    end

    // pixel side: random stall bursts, plus one long hold on request
    initial begin : pixel_sink
        int hold_left;
        int burst_left;
        hold_left    = 0;
        burst_left   = 0;
        pix_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (pix_hold_req) begin
                pix_hold_req = 1'b0;
                hold_left = 200;
            end
            if (hold_left > 0) begin
                hold_left--;
                pix_ch.ready <= 1'b0;
            end else if (!no_idle && burst_left > 0) begin
                burst_left--;
                pix_ch.ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(1, 9) - 1;
                pix_ch.ready <= 1'b0;
            end else begin
                pix_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("line_rect_rasterizer_unit_test NOT OK");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int clamp_coord(int v);
        if (v < -4096) return -4096;
        if (v > 4095) return 4095;
        return v;
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(logic [C_OP_W-1:0] op, int xs, int ys, int xe, int ye);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.operation <= op;
        cmd_ch.x_start   <= t_coord'(xs);
        cmd_ch.y_start   <= t_coord'(ys);
        cmd_ch.x_end     <= t_coord'(xe);
        cmd_ch.y_end     <= t_coord'(ye);
        @(posedge i_clk);
        while (cmd_ch.ready !== 1'b1) @(posedge i_clk);
        rasterize_word(op, t_coord'(xs), t_coord'(ys), t_coord'(xe), t_coord'(ye));
        words_sent++;
        @(negedge i_clk);
    endtask

    // coordinates of a step word are don't-care, so they carry random bits
    task automatic send_step();
        send_word(OP_STEP, int'(t_coord'($urandom)), int'(t_coord'($urandom)),
                  int'(t_coord'($urandom)), int'(t_coord'($urandom)));
    endtask

    task automatic draw(logic [C_OP_W-1:0] op, int x1, int y1, int x2, int y2, int steps);
        send_word(op, x1, y1, x2, y2);
        repeat (steps) send_step();
    endtask

    // lets every expected pixel come out, then waits for command words in flight
    task automatic wait_for_quiet();
        cmd_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // called at a falling edge, leaves valid high; the caller drops it after the last write
    task automatic write_register(logic [C_REG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) @(posedge i_clk);
        case (idx)
            REG_AREA_WIDTH:  cfg_width  = value[C_DIM_W-1:0];
            REG_AREA_HEIGHT: cfg_height = value[C_DIM_W-1:0];
            REG_ROW_PITCH:   cfg_pitch  = value[C_PITCH_W-1:0];
            REG_PIXEL_VALUE: cfg_value  = value;
            REG_PIXEL_BYTES: cfg_bytes  = value[C_BYTES_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_config(int w, int h, int pitch, logic [31:0] value, int nbytes);
        wait_for_quiet();
        write_register(REG_AREA_WIDTH, 32'(w));
        write_register(REG_AREA_HEIGHT, 32'(h));
        write_register(REG_ROW_PITCH, 32'(pitch));
        write_register(REG_PIXEL_VALUE, value);
        write_register(REG_PIXEL_BYTES, 32'(nbytes));
        cfg_ch.valid <= 1'b0;
    endtask

    // one command followed by its steps; sometimes cut short by the next command,
    // sometimes a fully random word
    task automatic send_shape_sequence(int cx, int cy, int spread);
        int sel, ext, x1, y1, x2, y2, limit, n;
        logic [C_OP_W-1:0] op;
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            op = C_OP_W'($urandom_range(0, 3));
            send_word(op, int'(t_coord'($urandom)), int'(t_coord'($urandom)),
                      int'(t_coord'($urandom)), int'(t_coord'($urandom)));
            return;
        end
        op  = C_OP_W'($urandom_range(0, 2));
        ext = (op == OP_FILL) ? rand_between(0, 5) : rand_between(0, 24);
        x1  = clamp_coord(cx + rand_between(-spread, spread));
        y1  = clamp_coord(cy + rand_between(-spread, spread));
        if ($urandom_range(0, 19) == 0) begin
            x2 = x1;
            y2 = y1;
        end else begin
            x2 = clamp_coord(x1 + rand_between(-ext, ext));
            y2 = clamp_coord(y1 + rand_between(-ext, ext));
        end
        limit = (sel < 18) ? rand_between(0, 3) : 400;
        send_word(op, x1, y1, x2, y2);
        n = 0;
        while (walk_busy && n < limit) begin
            send_step();
            n++;
        end
        if (limit == 400) repeat ($urandom_range(0, 2)) send_step();
    endtask

    task automatic run_random_block(int count, int cx, int cy, int spread);
        int first;
        first = words_sent;
        while (words_sent - first < count) send_shape_sequence(cx, cy, spread);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reset_defaults();
        // zero clip area after reset: nothing is written
        send_step();
        draw(OP_LINE, 0, 0, 2, 0, 3);
    endtask

    task automatic test_directed_cases();
        set_config(64, 48, 100, 32'hDEAD_BEEF, 4);
        send_step();
        draw(OP_LINE, -1, 0, 1, 1, 3);
        draw(OP_LINE, 1, 3, 0, 0, 3);
        draw(OP_LINE, 0, 2, 3, 0, 3);
        draw(OP_LINE, 0, 3, 1, 0, 3);
        draw(OP_LINE, 5, 5, 5, 5, 1);
        // outline of zero width skips its horizontal edges
        draw(OP_RECT, 2, 0, 2, 1, 2);
        draw(OP_RECT, 1, 1, 0, 0, 4);
        draw(OP_FILL, 1, 1, 0, 0, 4);
        // long commands dropped by the next command
        draw(OP_LINE, -4096, -4096, 4095, 4095, 2);
        draw(OP_FILL, 4095, 4095, -4096, -4096, 1);
        draw(OP_RECT, 3, 3, 3, 3, 1);
    endtask

    task automatic test_backpressure();
        set_config(40, 40, 40, $urandom, 2);
        pix_hold_req = 1'b1;
        draw(OP_FILL, 0, 0, 5, 5, 40);
    endtask

    task automatic test_random_clipped();
        set_config(64, 48, 64, $urandom, 4);
        run_random_block(650, 30, 20, 50);
    endtask

    task automatic test_random_index_wrap();
        // clip beyond the maximum area and the widest pitch, corners anywhere
        set_config(8191, 8191, 16383, 32'hFFFF_FFFF, 1);
        run_random_block(400, 0, 0, 4096);
    endtask

    task automatic test_random_sizes();
        int size_codes[6];
        int k;
        size_codes = '{0, 3, 5, 6, 7, 2};
        for (k = 0; k < 6; k++) begin
            set_config(rand_between(0, 8191), rand_between(0, 8191), rand_between(0, 16383),
                       $urandom, size_codes[k]);
            run_random_block(60, rand_between(-50, 200), rand_between(-50, 200), 100);
        end
    endtask

    task automatic test_streaming();
        set_config(4096, 4096, 8192, 32'h0, 4);
        no_idle = 1'b1;
        run_random_block(350, 10, 10, 30);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.operation = OP_STEP;
        cmd_ch.x_start   = '0;
        cmd_ch.y_start   = '0;
        cmd_ch.x_end     = '0;
        cmd_ch.y_end     = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_AREA_WIDTH;
        cfg_ch.data      = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_directed_cases();
        test_backpressure();
        test_random_clipped();
        test_random_index_wrap();
        test_random_sizes();
        test_streaming();
        wait_for_quiet();

        $display("sent %0d words, checked %0d pixel words, %0d mismatches",
                 words_sent, pixels_checked, error_count);
        $display("lines, outlines and fills under clipping, index wrap, all size codes, stalls");
        if (error_count == 0) begin
            $display("line_rect_rasterizer_unit_test OK");
        end else begin
            $display("line_rect_rasterizer_unit_test NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/lrr_pkg.sv
rtl/lrr_intf.sv
rtl/lrr_cfg_regs.sv
rtl/lrr_walker.sv
rtl/line_rect_rasterizer_unit.sv
tb/line_rect_rasterizer_unit_test.sv
